// File: rtl/core/nwsp_pkg.sv
// Package for the node weighted shortest path block.
// Holds item kinds, field widths and the records shared by the store, solver and top level.
// Depends on nothing.
package nwsp_pkg;

    localparam int NID_W  = 8;
    localparam int COST_W = 16;
    localparam int WT_W   = 17;
    localparam int DIST_W = 32;
    localparam int CNT_W  = 9;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_SOLVE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [NID_W-1:0] src;
        logic [NID_W-1:0] dst;
        logic [WT_W-1:0]  wt;
    } edge_rec_t;

    typedef struct packed {
        logic              reached;
        logic              finished;
        logic [DIST_W-1:0] dist_val;
    } node_rec_t;

    typedef struct packed {
        logic              load_we;
        logic [NID_W-1:0]  node_index;
        logic [COST_W-1:0] load_time;
        logic              edge_push;
        logic [NID_W-1:0]  edge_from;
        logic [NID_W-1:0]  edge_to;
        logic [COST_W-1:0] edge_cost;
        logic              clear;
    } gs_cmd_t;

    typedef struct packed {
        logic              reachable;
        logic [DIST_W-1:0] distance;
    } solve_res_t;

endpackage

// File: rtl/core/nwsp_relax_unit.sv
// Shared saturating add and compare unit of the shortest path solver.
// Used for both the minimum scan and edge relaxation; depends on nwsp_pkg.
module nwsp_relax_unit (
    input  logic [nwsp_pkg::DIST_W-1:0] base,
    input  logic [nwsp_pkg::WT_W-1:0]   addend,
    input  logic [nwsp_pkg::DIST_W-1:0] limit,
    output logic [nwsp_pkg::DIST_W-1:0] sum,
    output logic                        less
);

    logic [nwsp_pkg::DIST_W:0] wide_sum;

    assign wide_sum = {1'b0, base} + (nwsp_pkg::DIST_W + 1)'(addend);
    assign sum      = wide_sum[nwsp_pkg::DIST_W] ? '1 : wide_sum[nwsp_pkg::DIST_W-1:0];
    assign less     = sum < limit;

endmodule

// File: rtl/core/nwsp_graph_store.sv
// Load time store and edge store of the shortest path block.
// Takes load and edge items from the top level and serves edge reads to the solver;
// depends on nwsp_pkg.
module nwsp_graph_store #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 4096,
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nwsp_pkg::gs_cmd_t     cmd,
    output logic                  busy,
    input  logic [EAW-1:0]        edge_raddr,
    output nwsp_pkg::edge_rec_t   edge_rdata,
    output logic [nwsp_pkg::COST_W-1:0] load0,
    output logic [ECW-1:0]        edge_total,
    output logic                  overflow
);

    localparam int LOAD_DEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
    localparam int LAW        = $clog2(LOAD_DEPTH);

    logic [nwsp_pkg::COST_W-1:0] load_mem [LOAD_DEPTH];
    nwsp_pkg::edge_rec_t         edge_mem [MAX_EDGES];

    logic [LOAD_DEPTH-1:0]       load_valid_reg, load_valid_next;
    logic [nwsp_pkg::COST_W-1:0] load_rd_reg;
    nwsp_pkg::edge_rec_t         edge_rd_reg;
    logic                        pending_reg, pending_next;
    logic [ECW-1:0]              total_reg, total_next;
    logic                        overflow_reg, overflow_next;
    logic [nwsp_pkg::COST_W-1:0] load0_reg, load0_next;
    logic [nwsp_pkg::NID_W-1:0]  from_reg, to_reg;
    logic [nwsp_pkg::COST_W-1:0] cost_reg;

    logic                        load_hit;
    logic                        to_hit;
    logic [nwsp_pkg::COST_W-1:0] target_load;
    logic                        edge_we;
    nwsp_pkg::edge_rec_t         edge_wdata;

    assign load_hit = 32'(cmd.node_index) < LOAD_DEPTH;
    assign to_hit   = 32'(to_reg) < LOAD_DEPTH;

    always_comb
    begin
        target_load = '0;
        if (to_hit && load_valid_reg[to_reg[LAW-1:0]])
        begin
            target_load = load_rd_reg;
        end
    end

    assign edge_wdata.src = from_reg;
    assign edge_wdata.dst = to_reg;
    assign edge_wdata.wt  = nwsp_pkg::WT_W'(cost_reg) + nwsp_pkg::WT_W'(target_load);

    always_comb
    begin
        load_valid_next = load_valid_reg;
        pending_next    = 1'b0;
        total_next      = total_reg;
        overflow_next   = overflow_reg;
        load0_next      = load0_reg;
        edge_we         = 1'b0;
        if (cmd.load_we && load_hit)
        begin
            load_valid_next[cmd.node_index[LAW-1:0]] = 1'b1;
            if (cmd.node_index == '0)
            begin
                load0_next = cmd.load_time;
            end
        end
        if (cmd.edge_push)
        begin
            pending_next = 1'b1;
        end
        if (pending_reg)
        begin
            if (total_reg == ECW'(MAX_EDGES))
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                edge_we    = 1'b1;
                total_next = total_reg + 1'b1;
            end
        end
        if (cmd.clear)
        begin
            load_valid_next = '0;
            total_next      = '0;
            overflow_next   = 1'b0;
            load0_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid_reg <= '0;
            pending_reg    <= 1'b0;
            total_reg      <= '0;
            overflow_reg   <= 1'b0;
            load0_reg      <= '0;
        end
        else
        begin
            load_valid_reg <= load_valid_next;
            pending_reg    <= pending_next;
            total_reg      <= total_next;
            overflow_reg   <= overflow_next;
            load0_reg      <= load0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_push)
        begin
            from_reg <= cmd.edge_from;
            to_reg   <= cmd.edge_to;
            cost_reg <= cmd.edge_cost;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && load_hit)
        begin
            load_mem[cmd.node_index[LAW-1:0]] <= cmd.load_time;
        end
        load_rd_reg <= load_mem[cmd.edge_to[LAW-1:0]];
        if (edge_we)
        begin
            edge_mem[total_reg[EAW-1:0]] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    assign busy       = pending_reg;
    assign edge_rdata = edge_rd_reg;
    assign load0      = load0_reg;
    assign edge_total = total_reg;
    assign overflow   = overflow_reg;

endmodule

// File: rtl/core/nwsp_solver.sv
// Dijkstra sequencer of the shortest path block with its node state memory.
// Uses nwsp_relax_unit for every distance add and compare; reads edges from nwsp_graph_store.
// Depends on nwsp_pkg.
module nwsp_solver #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 4096,
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nwsp_pkg::CNT_W-1:0]   n_nodes,
    input  logic [nwsp_pkg::COST_W-1:0]  load0,
    input  logic [ECW-1:0]               edge_total,
    output logic [EAW-1:0]               edge_raddr,
    input  nwsp_pkg::edge_rec_t          edge_rdata,
    input  logic                         res_ready,
    output logic                         busy,
    output logic                         res_valid,
    output nwsp_pkg::solve_res_t         result
);

    localparam int NW = $clog2(MAX_NODES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_PICK,
        S_EREQ,
        S_EDATA,
        S_NDATA,
        S_TREQ,
        S_TREAD,
        S_RESULT
    } state_t;

    nwsp_pkg::node_rec_t node_mem [MAX_NODES];

    state_t                        state_reg, state_next;
    logic [nwsp_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [nwsp_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [nwsp_pkg::CNT_W-1:0]    j_reg, j_next;
    logic                          rv_reg, rv_next;
    logic [nwsp_pkg::CNT_W-1:0]    best_reg, best_next;
    logic [nwsp_pkg::DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic                          best_v_reg, best_v_next;
    logic [ECW-1:0]                e_reg, e_next;
    logic [nwsp_pkg::NID_W-1:0]    dst_reg, dst_next;
    logic [nwsp_pkg::WT_W-1:0]     wt_reg, wt_next;
    nwsp_pkg::solve_res_t          result_reg, result_next;
    logic                          res_valid_reg, res_valid_next;
    nwsp_pkg::node_rec_t           node_rd_reg;

    logic                          node_we;
    logic [NW-1:0]                 node_waddr;
    nwsp_pkg::node_rec_t           node_wdata;
    logic [NW-1:0]                 node_raddr;

    logic [nwsp_pkg::DIST_W-1:0]   unit_base;
    logic [nwsp_pkg::WT_W-1:0]     unit_addend;
    logic [nwsp_pkg::DIST_W-1:0]   unit_limit;
    logic [nwsp_pkg::DIST_W-1:0]   unit_sum;
    logic                          unit_less;

    nwsp_relax_unit u_unit (
        .base   (unit_base),
        .addend (unit_addend),
        .limit  (unit_limit),
        .sum    (unit_sum),
        .less   (unit_less)
    );

    always_comb
    begin
        if (state_reg == S_NDATA)
        begin
            unit_base   = best_dist_reg;
            unit_addend = wt_reg;
            unit_limit  = node_rd_reg.dist_val;
        end
        else
        begin
            unit_base   = node_rd_reg.dist_val;
            unit_addend = '0;
            unit_limit  = best_dist_reg;
        end
    end

    assign edge_raddr = e_reg[EAW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rv_next        = rv_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        best_v_next    = best_v_reg;
        e_next         = e_reg;
        dst_next       = dst_reg;
        wt_next        = wt_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg;
        node_we        = 1'b0;
        node_waddr     = NW'(i_reg);
        node_wdata     = '0;
        node_raddr     = NW'(i_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_nodes;
                    i_next     = '0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                node_we = 1'b1;
                if (i_reg == '0)
                begin
                    node_wdata.reached  = 1'b1;
                    node_wdata.dist_val = nwsp_pkg::DIST_W'(load0);
                end
                if (i_reg == n_reg - 1'b1)
                begin
                    i_next      = '0;
                    rv_next     = 1'b0;
                    best_v_next = 1'b0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (rv_reg && node_rd_reg.reached && !node_rd_reg.finished &&
                    (!best_v_reg || unit_less))
                begin
                    best_next      = j_reg;
                    best_dist_next = node_rd_reg.dist_val;
                    best_v_next    = 1'b1;
                end
                if (i_reg < n_reg)
                begin
                    rv_next = 1'b1;
                    j_next  = i_reg;
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                    if (!rv_reg)
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                if (!best_v_reg)
                begin
                    state_next = S_TREQ;
                end
                else
                begin
                    node_we             = 1'b1;
                    node_waddr          = NW'(best_reg);
                    node_wdata.reached  = 1'b1;
                    node_wdata.finished = 1'b1;
                    node_wdata.dist_val = best_dist_reg;
                    e_next              = '0;
                    state_next          = S_EREQ;
                end
            end
            S_EREQ:
            begin
                if (e_reg == edge_total)
                begin
                    i_next      = '0;
                    rv_next     = 1'b0;
                    best_v_next = 1'b0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    state_next = S_EDATA;
                end
            end
            S_EDATA:
            begin
                if ({1'b0, edge_rdata.src} == best_reg && {1'b0, edge_rdata.dst} < n_reg)
                begin
                    node_raddr = NW'(edge_rdata.dst);
                    dst_next   = edge_rdata.dst;
                    wt_next    = edge_rdata.wt;
                    state_next = S_NDATA;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_EREQ;
                end
            end
            S_NDATA:
            begin
                if (!node_rd_reg.reached || unit_less)
                begin
                    node_we             = 1'b1;
                    node_waddr          = NW'(dst_reg);
                    node_wdata.reached  = 1'b1;
                    node_wdata.finished = node_rd_reg.finished;
                    node_wdata.dist_val = unit_sum;
                end
                e_next     = e_reg + 1'b1;
                state_next = S_EREQ;
            end
            S_TREQ:
            begin
                node_raddr = NW'(n_reg - 1'b1);
                state_next = S_TREAD;
            end
            S_TREAD:
            begin
                result_next.reachable = node_rd_reg.reached;
                result_next.distance  = node_rd_reg.reached ? node_rd_reg.dist_val : '0;
                res_valid_next        = 1'b1;
                state_next            = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rv_reg        <= 1'b0;
            best_reg      <= '0;
            best_dist_reg <= '0;
            best_v_reg    <= 1'b0;
            e_reg         <= '0;
            dst_reg       <= '0;
            wt_reg        <= '0;
            result_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rv_reg        <= rv_next;
            best_reg      <= best_next;
            best_dist_reg <= best_dist_next;
            best_v_reg    <= best_v_next;
            e_reg         <= e_next;
            dst_reg       <= dst_next;
            wt_reg        <= wt_next;
            result_reg    <= result_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    assign busy      = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/core/node_weighted_shortest_path.sv
// Top level of the node weighted shortest path block: handshakes, node count register
// and result register. Instantiates nwsp_graph_store and nwsp_solver; depends on nwsp_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  kind, node_index, load_time, edge_from,
//                                            edge_to, edge_cost
//   out      output     out_valid / out_stall reachable, distance, edge_overflow
//   cfg      input      cfg_valid / cfg_ready cfg_data (node count)
//
// A load item does not stall the input; an edge item stalls it while the edge weight is formed
// from the registered load store read. A solve item makes a clearing pass over the node state,
// then for each reached node a scan of the n nodes in use and a pass over the E stored edges,
// through the single read port of the node state and edge memories.
// Reset clears all control state; the load store is cleared through its valid bits.
// The next item is taken while a result waits on a stalled output; a finished solve holds
// until the output register is free.
module node_weighted_shortest_path #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [nwsp_pkg::NID_W-1:0]    node_index,
    input  logic [nwsp_pkg::COST_W-1:0]   load_time,
    input  logic [nwsp_pkg::NID_W-1:0]    edge_from,
    input  logic [nwsp_pkg::NID_W-1:0]    edge_to,
    input  logic [nwsp_pkg::COST_W-1:0]   edge_cost,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          reachable,
    output logic [nwsp_pkg::DIST_W-1:0]   distance,
    output logic                          edge_overflow,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nwsp_pkg::CNT_W-1:0]    cfg_data
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    nwsp_pkg::gs_cmd_t             gs_cmd;
    logic                          gs_busy;
    logic [EAW-1:0]                edge_raddr;
    nwsp_pkg::edge_rec_t           edge_rdata;
    logic [nwsp_pkg::COST_W-1:0]   load0;
    logic [ECW-1:0]                edge_total;
    logic                          gs_overflow;

    logic                          sv_busy;
    logic                          sv_res_valid;
    nwsp_pkg::solve_res_t          sv_result;
    logic                          res_ready;
    logic                          handover;

    logic                          in_accept;
    logic [nwsp_pkg::CNT_W-1:0]    node_count_reg;
    logic [nwsp_pkg::CNT_W-1:0]    n_eff;
    logic                          out_valid_reg, out_valid_next;
    logic                          reachable_reg;
    logic [nwsp_pkg::DIST_W-1:0]   distance_reg;
    logic                          overflow_reg;

    assign in_stall  = gs_busy || sv_busy;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = nwsp_pkg::CNT_W'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            n_eff = nwsp_pkg::CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign res_ready = !out_valid_reg || !out_stall;
    assign handover  = sv_res_valid && res_ready;

    always_comb
    begin
        gs_cmd.load_we    = in_accept && (kind == nwsp_pkg::KIND_LOAD);
        gs_cmd.node_index = node_index;
        gs_cmd.load_time  = load_time;
        gs_cmd.edge_push  = in_accept && (kind == nwsp_pkg::KIND_EDGE);
        gs_cmd.edge_from  = edge_from;
        gs_cmd.edge_to    = edge_to;
        gs_cmd.edge_cost  = edge_cost;
        gs_cmd.clear      = handover;
    end

    nwsp_graph_store #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (gs_cmd),
        .busy       (gs_busy),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .load0      (load0),
        .edge_total (edge_total),
        .overflow   (gs_overflow)
    );

    nwsp_solver #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_solver (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept && (kind == nwsp_pkg::KIND_SOLVE)),
        .n_nodes    (n_eff),
        .load0      (load0),
        .edge_total (edge_total),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .res_ready  (res_ready),
        .busy       (sv_busy),
        .res_valid  (sv_res_valid),
        .result     (sv_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (handover)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= nwsp_pkg::CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (handover)
        begin
            reachable_reg <= sv_result.reachable;
            distance_reg  <= sv_result.distance;
            overflow_reg  <= gs_overflow;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reachable     = reachable_reg;
    assign distance      = distance_reg;
    assign edge_overflow = overflow_reg;

endmodule

// File: rtl/core/nwsp_checker.sv
// Port level checks for the node weighted shortest path block, bound to its top level.
// Depends on nwsp_pkg and node_weighted_shortest_path.
module nwsp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  kind,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        reachable,
    input logic [nwsp_pkg::DIST_W-1:0] distance,
    input logic                        edge_overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(reachable) && $stable(distance) &&
        $stable(edge_overflow))
        else $error("Stalled output item changed.");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reachable |-> distance == '0)
        else $error("Unreachable result carries a nonzero distance.");

    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (kind == nwsp_pkg::KIND_EDGE || kind == nwsp_pkg::KIND_SOLVE) |=> in_stall)
        else $error("Edge or solve item did not busy the block.");

endmodule

bind node_weighted_shortest_path nwsp_checker u_nwsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reachable     (reachable),
    .distance      (distance),
    .edge_overflow (edge_overflow)
);

// File: dv/tb_node_weighted_shortest_path.sv
`timescale 1ns / 100ps
// Testbench for node_weighted_shortest_path: directed graphs, a full edge store and random
// graph cases, each solve checked against a shortest path predictor kept in this file.
// Depends on nwsp_pkg and the node_weighted_shortest_path RTL only.
module tb_node_weighted_shortest_path;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 4096;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 2000;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic                        reachable;
        logic [nwsp_pkg::DIST_W-1:0] distance;
        logic                        overflow;
    } path_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [1:0]                  kind = nwsp_pkg::KIND_LOAD;
    logic [nwsp_pkg::NID_W-1:0]  node_index = '0;
    logic [nwsp_pkg::COST_W-1:0] load_time = '0;
    logic [nwsp_pkg::NID_W-1:0]  edge_from = '0;
    logic [nwsp_pkg::NID_W-1:0]  edge_to = '0;
    logic [nwsp_pkg::COST_W-1:0] edge_cost = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        reachable;
    logic [nwsp_pkg::DIST_W-1:0] distance;
    logic                        edge_overflow;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [nwsp_pkg::CNT_W-1:0]  cfg_data = '0;

    logic [nwsp_pkg::CNT_W-1:0]  node_count_setting = 9'd1;
    logic [nwsp_pkg::COST_W-1:0] load_tbl [MAX_NODES];
    nwsp_pkg::edge_rec_t         edge_tbl [MAX_EDGES];
    int unsigned                 edge_cnt = 0;
    bit                          edges_dropped = 1'b0;
    path_result_t                pending_paths [$];

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    bit          hold_start = 1'b0;
    int          hold_left = 0;
    int unsigned items_sent = 0;
    int unsigned solves_sent = 0;
    int unsigned paths_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    node_weighted_shortest_path #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .node_index(node_index),
        .load_time(load_time),
        .edge_from(edge_from),
        .edge_to(edge_to),
        .edge_cost(edge_cost),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .reachable(reachable),
        .distance(distance),
        .edge_overflow(edge_overflow),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        foreach (load_tbl[i])
        begin
            load_tbl[i] = '0;
        end
    end

    function automatic int unsigned nodes_in_use();
        if (node_count_setting == '0)
        begin
            return 1;
        end
        if (node_count_setting > MAX_NODES)
        begin
            return MAX_NODES;
        end
        return 32'(node_count_setting);
    endfunction

    function automatic path_result_t shortest_to_last();
        int unsigned                 n;
        int unsigned                 best;
        int unsigned                 t;
        logic [nwsp_pkg::DIST_W-1:0] node_dist [MAX_NODES];
        bit                          seen [MAX_NODES];
        bit                          done [MAX_NODES];
        logic [nwsp_pkg::DIST_W:0]   cand;
        path_result_t                res;
        n = nodes_in_use();
        foreach (seen[i])
        begin
            seen[i] = 1'b0;
            done[i] = 1'b0;
            node_dist[i] = '0;
        end
        node_dist[0] = nwsp_pkg::DIST_W'(load_tbl[0]);
        seen[0] = 1'b1;
        best = 0;
        while (best != n)
        begin
            best = n;
            for (int i = 0; i < n; i++)
            begin
                if (seen[i] && !done[i] && (best == n || node_dist[i] < node_dist[best]))
                begin
                    best = i;
                end
            end
            if (best != n)
            begin
                done[best] = 1'b1;
                for (int e = 0; e < edge_cnt; e++)
                begin
                    t = 32'(edge_tbl[e].dst);
                    if (edge_tbl[e].src == best && t < n)
                    begin
                        cand = {1'b0, node_dist[best]} +
                               (nwsp_pkg::DIST_W + 1)'(edge_tbl[e].wt);
                        if (cand[nwsp_pkg::DIST_W])
                        begin
                            cand = {1'b0, {nwsp_pkg::DIST_W{1'b1}}};
                        end
                        if (!seen[t] || cand[nwsp_pkg::DIST_W-1:0] < node_dist[t])
                        begin
                            node_dist[t] = cand[nwsp_pkg::DIST_W-1:0];
                            seen[t] = 1'b1;
                        end
                    end
                end
            end
        end
        res.reachable = seen[n-1];
        res.distance = seen[n-1] ? node_dist[n-1] : '0;
        res.overflow = edges_dropped;
        return res;
    endfunction

    function automatic void apply_to_graph(input logic [1:0] k,
                                           input logic [nwsp_pkg::NID_W-1:0] idx,
                                           input logic [nwsp_pkg::COST_W-1:0] lt,
                                           input logic [nwsp_pkg::NID_W-1:0] fr,
                                           input logic [nwsp_pkg::NID_W-1:0] to,
                                           input logic [nwsp_pkg::COST_W-1:0] cost);
        path_result_t solved;
        if (k == nwsp_pkg::KIND_LOAD)
        begin
            load_tbl[idx] = lt;
        end
        else if (k == nwsp_pkg::KIND_EDGE)
        begin
            if (edge_cnt >= MAX_EDGES)
            begin
                edges_dropped = 1'b1;
            end
            else
            begin
                edge_tbl[edge_cnt].src = fr;
                edge_tbl[edge_cnt].dst = to;
                edge_tbl[edge_cnt].wt = nwsp_pkg::WT_W'(cost) + nwsp_pkg::WT_W'(load_tbl[to]);
                edge_cnt++;
            end
        end
        else if (k == nwsp_pkg::KIND_SOLVE)
        begin
            solved = shortest_to_last();
            pending_paths.insert(pending_paths.size(), solved);
            edge_cnt = 0;
            edges_dropped = 1'b0;
            foreach (load_tbl[i])
            begin
                load_tbl[i] = '0;
            end
        end
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [nwsp_pkg::NID_W-1:0] idx,
                             input logic [nwsp_pkg::COST_W-1:0] lt,
                             input logic [nwsp_pkg::NID_W-1:0] fr,
                             input logic [nwsp_pkg::NID_W-1:0] to,
                             input logic [nwsp_pkg::COST_W-1:0] cost);
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        node_index <= idx;
        load_time <= lt;
        edge_from <= fr;
        edge_to <= to;
        edge_cost <= cost;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        apply_to_graph(k, idx, lt, fr, to, cost);
        if (k != KIND_UNUSED)
        begin
            items_sent++;
        end
        if (k == nwsp_pkg::KIND_SOLVE)
        begin
            solves_sent++;
        end
    endtask

    task automatic send_load(input logic [nwsp_pkg::NID_W-1:0] idx,
                             input logic [nwsp_pkg::COST_W-1:0] lt);
        send_item(nwsp_pkg::KIND_LOAD, idx, lt, nwsp_pkg::NID_W'($urandom),
                  nwsp_pkg::NID_W'($urandom), nwsp_pkg::COST_W'($urandom));
    endtask

    task automatic send_edge(input logic [nwsp_pkg::NID_W-1:0] fr,
                             input logic [nwsp_pkg::NID_W-1:0] to,
                             input logic [nwsp_pkg::COST_W-1:0] cost);
        send_item(nwsp_pkg::KIND_EDGE, nwsp_pkg::NID_W'($urandom),
                  nwsp_pkg::COST_W'($urandom), fr, to, cost);
    endtask

    task automatic send_solve();
        send_item(nwsp_pkg::KIND_SOLVE, nwsp_pkg::NID_W'($urandom),
                  nwsp_pkg::COST_W'($urandom), nwsp_pkg::NID_W'($urandom),
                  nwsp_pkg::NID_W'($urandom), nwsp_pkg::COST_W'($urandom));
    endtask

    task automatic send_noise();
        send_item(KIND_UNUSED, nwsp_pkg::NID_W'($urandom), nwsp_pkg::COST_W'($urandom),
                  nwsp_pkg::NID_W'($urandom), nwsp_pkg::NID_W'($urandom),
                  nwsp_pkg::COST_W'($urandom));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_paths.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [nwsp_pkg::CNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        node_count_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [nwsp_pkg::NID_W-1:0] pick_node(input int unsigned n);
        if ($urandom_range(0, 9) == 0)
        begin
            return nwsp_pkg::NID_W'($urandom);
        end
        return nwsp_pkg::NID_W'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [nwsp_pkg::COST_W-1:0] pick_weight();
        if ($urandom_range(0, 3) == 0)
        begin
            return nwsp_pkg::COST_W'($urandom);
        end
        return nwsp_pkg::COST_W'($urandom_range(0, 20));
    endfunction

    task automatic random_graph_case(input bit reconfigure);
        int unsigned                n;
        int unsigned                loads;
        int unsigned                edges;
        logic [nwsp_pkg::CNT_W-1:0] setting;
        if (reconfigure)
        begin
            case ($urandom_range(0, 9))
                0: setting = nwsp_pkg::CNT_W'($urandom_range(0, 1));
                1: setting = nwsp_pkg::CNT_W'($urandom_range(13, 511));
                default: setting = nwsp_pkg::CNT_W'($urandom_range(2, 12));
            endcase
            write_node_count(setting);
        end
        n = nodes_in_use();
        loads = $urandom_range(0, (n < 12) ? n : 12);
        repeat (loads) send_load(pick_node(n), pick_weight());
        edges = $urandom_range(0, (n < 8) ? 3 * n : 24);
        for (int e = 0; e < edges; e++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_noise();
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_load(pick_node(n), pick_weight());
            end
            send_edge(pick_node(n), pick_node(n), pick_weight());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_edge(pick_node(n), nwsp_pkg::NID_W'(n - 1), pick_weight());
        end
        send_solve();
    endtask

    task automatic test_single_node();
        send_load(8'd0, 16'hFFFF);
        send_edge(8'd0, 8'd0, 16'hFFFF);
        send_solve();
        write_node_count(9'd0);
        send_load(8'd0, 16'd5);
        send_noise();
        send_solve();
        drain_results();
    endtask

    task automatic test_small_graph();
        write_node_count(9'd4);
        send_load(8'd1, 16'd2);
        send_load(8'd2, 16'd2);
        send_load(8'd255, 16'hFFFF);
        send_edge(8'd0, 8'd1, 16'd1);
        send_edge(8'd0, 8'd2, 16'd1);
        send_edge(8'd1, 8'd3, 16'd10);
        send_edge(8'd2, 8'd3, 16'd9);
        send_edge(8'd9, 8'd3, 16'd0);
        send_edge(8'd0, 8'd200, 16'd0);
        send_load(8'd3, 16'd4);
        send_solve();
        send_solve();
        drain_results();
    endtask

    task automatic test_max_nodes();
        write_node_count(9'd511);
        send_load(8'd255, 16'h8000);
        send_load(8'd0, 16'd1);
        send_edge(8'd0, 8'd255, 16'hFFFF);
        send_edge(8'd128, 8'd255, 16'd0);
        send_edge(8'd0, 8'd128, 16'd7);
        send_solve();
        write_node_count(9'd256);
        send_edge(8'd0, 8'd254, 16'd3);
        send_solve();
        drain_results();
    endtask

    task automatic test_edge_overflow();
        write_node_count(9'd2);
        send_load(8'd1, 16'd9);
        for (int e = 0; e < MAX_EDGES + 3; e++)
        begin
            send_edge(($urandom_range(0, 7) == 0) ? nwsp_pkg::NID_W'($urandom) : 8'd0,
                      nwsp_pkg::NID_W'($urandom_range(0, 1)), nwsp_pkg::COST_W'($urandom));
        end
        send_solve();
        send_solve();
        drain_results();
    endtask

    task automatic test_random_graphs(input int unsigned in_pct, input int unsigned out_pct,
                                      input int unsigned target);
        int unsigned first;
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        first = items_sent;
        while (items_sent - first < target)
        begin
            random_graph_case($urandom_range(0, 2) == 0);
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        write_node_count(9'd6);
        hold_start = 1'b1;
        repeat (4) random_graph_case(1'b0);
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_path
        path_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_paths.size() == 0)
            begin
                $display("%0t: expected no item, actual reachable %0b distance %0d overflow %0b",
                         $time, reachable, distance, edge_overflow);
                mismatch_count++;
            end
            else
            begin
                want = pending_paths.pop_front();
                paths_checked++;
                if (reachable !== want.reachable)
                begin
                    $display("%0t: reachable expected %0b, actual %0b",
                             $time, want.reachable, reachable);
                    mismatch_count++;
                end
                if (distance !== want.distance)
                begin
                    $display("%0t: distance expected %0d, actual %0d",
                             $time, want.distance, distance);
                    mismatch_count++;
                end
                if (edge_overflow !== want.overflow)
                begin
                    $display("%0t: edge_overflow expected %0b, actual %0b",
                             $time, want.overflow, edge_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, cycle_count, pending_paths.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_single_node();
        test_small_graph();
        test_max_nodes();
        test_edge_overflow();
        test_random_graphs(0, 0, 190);
        test_random_graphs(86, 0, 190);
        test_random_graphs(0, 86, 190);
        test_random_graphs(29, 29, 190);
        test_output_backpressure();
        drain_results();
        $display("Sent %0d items with %0d solves; %0d results checked in %0d cycles.",
                 items_sent, solves_sent, paths_checked, cycle_count);
        $display("Covered one node, count limits, a full edge store, idle mixes, long hold.");
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// File: node_weighted_shortest_path.f
rtl/core/nwsp_pkg.sv
rtl/core/nwsp_relax_unit.sv
rtl/core/nwsp_graph_store.sv
rtl/core/nwsp_solver.sv
rtl/core/node_weighted_shortest_path.sv
rtl/core/nwsp_checker.sv
dv/tb_node_weighted_shortest_path.sv
